// File: hw/rtl/c39_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c39_pkg: shared types and constants for the code 39 symbol decoder
// Symbol table, queue entry layout and string position codes.
// ----------------------------------------------------------------------------
package c39_pkg;

  localparam int TABLE_ENTRIES = 44;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int PAT_W         = 9;
  localparam int ASCII_W       = 7;
  localparam int WEIGHT_W      = 6;
  localparam logic [WEIGHT_W-1:0] CHECK_MOD = 6'd43;

  // table order: 0-9, A-Z, '-', '.', ' ', '*', '$', '/', '+', '%'
  localparam logic [PAT_W-1:0] PATTERN_ROM [TABLE_ENTRIES] = '{
    9'h034, 9'h121, 9'h061, 9'h160, 9'h031, 9'h130, 9'h070, 9'h025, 9'h124, 9'h064,
    9'h109, 9'h049, 9'h148, 9'h019, 9'h118, 9'h058, 9'h00D, 9'h10C, 9'h04C, 9'h01C,
    9'h103, 9'h043, 9'h142, 9'h013, 9'h112, 9'h052, 9'h007, 9'h106, 9'h046, 9'h016,
    9'h181, 9'h0C1, 9'h1C0, 9'h091, 9'h190, 9'h0D0,
    9'h085, 9'h184, 9'h0C4, 9'h094, 9'h0A8, 9'h0A2, 9'h08A, 9'h02A
  };

  localparam logic [ASCII_W-1:0] PUNCT_ASCII [8] = '{
    7'd45, 7'd46, 7'd32, 7'd42, 7'd36, 7'd47, 7'd43, 7'd37
  };

  localparam logic [IDX_W-1:0] IDX_DIGIT_END  = IDX_W'(10);
  localparam logic [IDX_W-1:0] IDX_ALPHA_END  = IDX_W'(36);
  localparam logic [IDX_W-1:0] IDX_ASTERISK   = IDX_W'(39);
  localparam logic [ASCII_W-1:0] DIGIT_OFFSET = 7'd48;
  localparam logic [ASCII_W-1:0] ALPHA_OFFSET = 7'd55;

  typedef struct packed {
    logic [ASCII_W-1:0]  ascii_char;
    logic [WEIGHT_W-1:0] check_value;
    logic                symbol_valid;
    logic                last_symbol;
  } sym_entry_t;

  typedef enum logic [1:0] {
    POS_START = 2'd0,
    POS_OPEN  = 2'd1,
    POS_HELD  = 2'd2
  } pos_t;

endpackage
`default_nettype wire

// File: hw/rtl/c39_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c39 channel interfaces
// Symbol input channel and decoded result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface c39_sym_if;
  logic       valid;
  logic       ready;
  logic [8:0] symbol_pattern;
  logic       last_symbol;

  modport source (output valid, symbol_pattern, last_symbol, input ready);
  modport sink   (input valid, symbol_pattern, last_symbol, output ready);
endinterface

interface c39_res_if;
  logic       valid;
  logic       ready;
  logic [6:0] ascii_char;
  logic [5:0] check_value;
  logic       symbol_valid;
  logic       string_end;
  logic       check_ok;

  modport source (output valid, ascii_char, check_value, symbol_valid, string_end,
                  check_ok, input ready);
  modport sink   (input valid, ascii_char, check_value, symbol_valid, string_end,
                  check_ok, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/c39_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c39_front: symbol table match and classification
// Matches the pattern against all table entries in parallel and forms the
// character and check weight for the queue.
// ----------------------------------------------------------------------------
module c39_front
  import c39_pkg::*;
(
  c39_sym_if.sink          sym,
  input  logic             q_ready,
  output logic             q_push,
  output sym_entry_t       q_entry
);

  logic [IDX_W-1:0] idx;
  logic             hit;
  logic [IDX_W-1:0] punct_off;

  // patterns are distinct, so at most one entry hits
  always_comb begin
    idx = '0;
    hit = 1'b0;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (sym.symbol_pattern == PATTERN_ROM[k]) begin
        idx = idx | IDX_W'(k);
        hit = 1'b1;
      end
    end
  end

  assign punct_off = idx - IDX_ALPHA_END;

  always_comb begin
    q_entry.ascii_char   = '0;
    q_entry.check_value  = '0;
    q_entry.symbol_valid = hit;
    q_entry.last_symbol  = sym.last_symbol;
    if (hit) begin
      if (idx < IDX_DIGIT_END) begin
        q_entry.ascii_char = ASCII_W'(idx) + DIGIT_OFFSET;
      end else if (idx < IDX_ALPHA_END) begin
        q_entry.ascii_char = ASCII_W'(idx) + ALPHA_OFFSET;
      end else begin
        q_entry.ascii_char = PUNCT_ASCII[punct_off[2:0]];
      end
      // asterisk weighs nothing, entries after it shift down by one
      if (idx < IDX_ASTERISK) begin
        q_entry.check_value = WEIGHT_W'(idx);
      end else if (idx == IDX_ASTERISK) begin
        q_entry.check_value = '0;
      end else begin
        q_entry.check_value = WEIGHT_W'(idx - IDX_W'(1));
      end
    end
  end

  assign sym.ready = q_ready;
  assign q_push    = sym.valid & q_ready;

endmodule
`default_nettype wire

// File: hw/rtl/c39_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c39_queue: two-entry queue between classifier and string checker
// Lets the front keep taking symbols while the back waits on its receiver.
// ----------------------------------------------------------------------------
module c39_queue
  import c39_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  sym_entry_t push_entry,
  output logic       push_ready,
  input  logic       pop,
  output logic       pop_valid,
  output sym_entry_t pop_entry
);

  sym_entry_t  entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_entry  = entries[rd_ptr];

endmodule
`default_nettype wire

// File: hw/rtl/c39_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c39_back: string tracking and mod-43 check
// Follows start, data, check and stop symbols, keeps the running sum and
// drives the registered result channel.
// ----------------------------------------------------------------------------
module c39_back
  import c39_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  sym_entry_t q_entry,
  output logic       q_pop,
  c39_res_if.source  res
);

  pos_t                pos;
  pos_t                pos_next;
  logic [WEIGHT_W-1:0] running_sum;
  logic [WEIGHT_W-1:0] running_sum_next;
  logic [WEIGHT_W-1:0] held_value;
  logic [WEIGHT_W-1:0] held_value_next;
  logic [WEIGHT_W:0]   sum_raw;
  logic                check_ok_next;
  logic                res_valid;

  assign q_pop = q_valid & (~res_valid | res.ready);

  // next position
  always_comb begin
    if (q_entry.last_symbol) begin
      pos_next = POS_START;
    end else begin
      unique case (pos)
        POS_START: pos_next = POS_OPEN;
        default:   pos_next = POS_HELD;
      endcase
    end
  end

  // sum, held weight and check flag
  always_comb begin
    sum_raw          = {1'b0, running_sum} + {1'b0, held_value};
    running_sum_next = running_sum;
    held_value_next  = held_value;
    check_ok_next    = 1'b0;
    if (q_entry.last_symbol) begin
      running_sum_next = '0;
      held_value_next  = '0;
      check_ok_next    = (pos != POS_START) && (pos != POS_OPEN) &&
                         (running_sum == held_value);
    end else begin
      unique case (pos)
        POS_START: begin
          running_sum_next = '0;
          held_value_next  = '0;
        end
        POS_OPEN: begin
          held_value_next = q_entry.check_value;
        end
        default: begin
          // both terms below 43, one subtract folds the sum
          if (sum_raw >= {1'b0, CHECK_MOD}) begin
            running_sum_next = WEIGHT_W'(sum_raw - {1'b0, CHECK_MOD});
          end else begin
            running_sum_next = sum_raw[WEIGHT_W-1:0];
          end
          held_value_next = q_entry.check_value;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= POS_START;
      running_sum <= '0;
      held_value  <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (q_pop) begin
        pos         <= pos_next;
        running_sum <= running_sum_next;
        held_value  <= held_value_next;
        res_valid   <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res.ascii_char   <= q_entry.ascii_char;
      res.check_value  <= q_entry.check_value;
      res.symbol_valid <= q_entry.symbol_valid;
      res.string_end   <= q_entry.last_symbol;
      res.check_ok     <= check_ok_next;
    end
  end

  assign res.valid = res_valid;

endmodule
`default_nettype wire

// File: hw/rtl/code39_symbol_decode_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// code39_symbol_decode_check: code 39 symbol decoder with mod-43 check
// Decodes one wide/narrow symbol pattern per beat and checks the string.
// ----------------------------------------------------------------------------
// Usage:
//   sym carries one symbol per beat: a 9-bit pattern, first element in the
//   msb, and last_symbol marking the stop symbol of a string.
//   res carries one result per symbol: the ascii character (0 when the
//   pattern is not in the table), its mod-43 weight, a match flag,
//   string_end on the stop symbol and check_ok, set on the stop symbol when
//   the data weights summed mod 43 equal the weight of the check symbol.
//   The first symbol of a string is the start symbol; the one before the
//   stop symbol is the check symbol.
//   An accepted beat is registered in the queue and then in the result
//   register. Throughput is one symbol per cycle while res is not stalled,
//   set by the parallel table match in front and the sum update in back.
//   A two-entry queue and the result register let sym keep being accepted
//   while res is stalled; sym.ready drops once the queue is full.
//   Reset empties the queue and the result register and returns the string
//   tracking to waiting for a start symbol.
// ----------------------------------------------------------------------------
module code39_symbol_decode_check
  import c39_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  c39_sym_if.sink   sym,
  c39_res_if.source res
);

  logic       q_push;
  logic       q_ready;
  sym_entry_t q_in;
  logic       q_valid;
  logic       q_pop;
  sym_entry_t q_out;

  c39_front u_front (
    .sym     (sym),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_entry (q_in)
  );

  c39_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (q_out)
  );

  c39_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_entry (q_out),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule
`default_nettype wire

// File: hw/rtl/c39_check_sva.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c39_check_sva: port-level checks for the code 39 decoder
// Watches the result channel for reset, stall and consistency rules.
// ----------------------------------------------------------------------------
module c39_check_sva (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       res_valid,
  input wire logic       res_ready,
  input wire logic [6:0] res_ascii_char,
  input wire logic [5:0] res_check_value,
  input wire logic       res_symbol_valid,
  input wire logic       res_string_end,
  input wire logic       res_check_ok
);

  // a stalled result stays up
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  a_ok_on_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_check_ok |-> res_string_end)
    else $error("check_ok outside a stop symbol");

  // an unmatched pattern decodes to nothing
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_symbol_valid |-> res_ascii_char == 7'd0 && res_check_value == 6'd0)
    else $error("unmatched symbol with nonzero fields");

  a_valid_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_symbol_valid |-> res_ascii_char != 7'd0 && res_check_value < 6'd43)
    else $error("matched symbol with bad fields");

endmodule

bind code39_symbol_decode_check c39_check_sva u_check_sva (
  .clk              (clk),
  .rst              (rst),
  .res_valid        (res.valid),
  .res_ready        (res.ready),
  .res_ascii_char   (res.ascii_char),
  .res_check_value  (res.check_value),
  .res_symbol_valid (res.symbol_valid),
  .res_string_end   (res.string_end),
  .res_check_ok     (res.check_ok)
);
`default_nettype wire
